// ===== src/intel_hex_record_parser_assert.svh =====
// Assertion macros used by the Intel HEX record parser core.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihex assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihex assertion failed");

`endif

// ===== src/ihex_pkg.sv =====
// Shared types, codes and the hex digit decoder for the Intel HEX record parser.
// No dependencies.
package ihex_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } ihex_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [2:0]  fault_code;
  } ihex_out_t;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_START = 3'd0;
  localparam logic [2:0] ERR_TRUNC = 3'd1;
  localparam logic [2:0] ERR_DIGIT = 3'd2;
  localparam logic [2:0] ERR_SUM   = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;

  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_UPPER = 8'h04;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX  = 10'd1023;
  localparam logic [POS_W-1:0] MIN_LINE = 10'd11;

  // Bit 4 is set for a legal hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

// ===== src/ihex_in_reg.sv =====
// Input register of the Intel HEX record parser: holds one item until the core takes it.
// Depends on ihex_pkg.
module ihex_in_reg
  import ihex_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ihex_in_t in_item,
  input  logic     res_ready,
  output logic     s1_valid,
  output ihex_in_t s1_item
);

  logic     valid_r, valid_nxt;
  ihex_in_t item_r;
  logic     accept;

  assign in_stall = valid_r && !res_ready;
  assign accept   = in_valid && !in_stall;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (res_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) item_r <= in_item;
  end

endmodule

// ===== src/ihex_core.sv =====
// Record decoding state and per-character step of the Intel HEX record parser.
// Depends on ihex_pkg and intel_hex_record_parser_assert.svh.
`include "intel_hex_record_parser_assert.svh"
module ihex_core
  import ihex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  ihex_in_t  item,
  output logic      res_valid,
  output ihex_out_t res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             colon_r, colon_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      raddr_r, raddr_nxt;
  logic [7:0]       rtype_r, rtype_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      pend_r, pend_nxt;
  logic [15:0]      upper_r, upper_nxt;
  logic             bad_r, bad_nxt;
  logic             eof_r, eof_nxt;
  logic             halted_r, halted_nxt;
  logic             seen_r, seen_nxt;
  logic [31:0]      high_r, high_nxt;
  logic             hbad_r, hbad_nxt;

  logic [POS_W-1:0] q;
  logic [8:0]       k;
  logic [4:0]       hv;
  logic [7:0]       bval;
  logic [7:0]       idx;
  logic [31:0]      waddr;
  logic [POS_W-1:0] need_len;
  logic             line_err;
  logic [2:0]       line_code;
  logic             do_finish;

  always_comb begin
    q        = pos_r - 10'd1;
    k        = q[POS_W-1:1];
    hv       = hex_value(item.ch);
    bval     = {nib_r, hv[4] ? hv[3:0] : 4'd0};
    idx      = 8'(k - 9'd4);
    waddr    = {upper_r, 16'd0} + {16'd0, raddr_r} + {24'd0, idx};
    need_len = MIN_LINE + {1'b0, len_r, 1'b0};

    line_err  = 1'b1;
    line_code = ERR_START;
    if (!colon_r || pos_r < MIN_LINE) line_code = ERR_START;
    else if (bad_r) line_code = ERR_DIGIT;
    else if (pos_r < need_len) line_code = ERR_TRUNC;
    else if (sum_r != 8'd0) line_code = ERR_SUM;
    else line_err = 1'b0;

    pos_nxt = pos_r;     colon_nxt = colon_r; nib_nxt = nib_r;
    len_nxt = len_r;     raddr_nxt = raddr_r; rtype_nxt = rtype_r;
    sum_nxt = sum_r;     pend_nxt = pend_r;   upper_nxt = upper_r;
    bad_nxt = bad_r;     eof_nxt = eof_r;     halted_nxt = halted_r;
    seen_nxt = seen_r;   high_nxt = high_r;   hbad_nxt = hbad_r;
    do_finish = 1'b0;
    res_valid = 1'b0;
    res = '0;

    if (fire && !halted_r) begin
      if (item.end_of_input) begin
        do_finish  = !eof_r && pos_r != '0;
        halted_nxt = 1'b1;
        res_valid  = 1'b1;
        if (do_finish && line_err) begin
          res.kind       = KIND_ERROR;
          res.fault_code = line_code;
        end else if (!seen_r) begin
          res.kind       = KIND_ERROR;
          res.fault_code = ERR_EMPTY;
        end else begin
          res.kind    = KIND_DONE;
          res.address = high_r;
        end
      end else if (!eof_r) begin
        if (item.ch == CH_NL) begin
          if (pos_r != '0) begin
            do_finish = 1'b1;
            if (line_err) begin
              halted_nxt     = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.fault_code = line_code;
            end
          end
        end else begin
          if (pos_r < POS_MAX) pos_nxt = pos_r + 10'd1;
          if (pos_r == '0) begin
            colon_nxt = (item.ch == CH_COLON);
          end else if (pos_r != POS_MAX) begin
            if (!q[0]) begin
              hbad_nxt = !hv[4];
              nib_nxt  = hv[4] ? hv[3:0] : 4'd0;
            end else if (!(k >= 9'd4 && k > 9'd4 + {1'b0, len_r})) begin
              if (hbad_r || !hv[4]) bad_nxt = 1'b1;
              sum_nxt = sum_r + bval;
              if (k == 9'd0) len_nxt = bval;
              else if (k == 9'd1) raddr_nxt = {bval, raddr_r[7:0]};
              else if (k == 9'd2) raddr_nxt = {raddr_r[15:8], bval};
              else if (k == 9'd3) rtype_nxt = bval;
              else if (k < 9'd4 + {1'b0, len_r}) begin
                if (rtype_r == REC_DATA && colon_r && !bad_nxt) begin
                  if (!seen_r || waddr > high_r) high_nxt = waddr;
                  seen_nxt    = 1'b1;
                  res_valid   = 1'b1;
                  res.kind    = KIND_WRITE;
                  res.address = waddr;
                  res.data    = bval;
                end else if (rtype_r == REC_UPPER) begin
                  if (idx == 8'd0) pend_nxt = {bval, pend_r[7:0]};
                  else if (idx == 8'd1) pend_nxt = {pend_r[15:8], bval};
                end
              end
            end
          end
        end
      end
    end

    if (do_finish) begin
      if (!line_err) begin
        if (rtype_r == REC_EOF) eof_nxt = 1'b1;
        else if (rtype_r == REC_UPPER && len_r == 8'd2) upper_nxt = pend_r;
      end
      pos_nxt = '0;  colon_nxt = 1'b0; nib_nxt = 4'd0;  len_nxt = 8'd0;
      raddr_nxt = 16'd0; rtype_nxt = 8'd0; sum_nxt = 8'd0; pend_nxt = 16'd0;
      bad_nxt = 1'b0; hbad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;    colon_r <= 1'b0; nib_r <= 4'd0;   len_r <= 8'd0;
      raddr_r <= 16'd0; rtype_r <= 8'd0; sum_r <= 8'd0; pend_r <= 16'd0;
      upper_r <= 16'd0; bad_r <= 1'b0; eof_r <= 1'b0;  halted_r <= 1'b0;
      seen_r <= 1'b0; high_r <= 32'd0; hbad_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;     colon_r <= colon_nxt; nib_r <= nib_nxt;
      len_r <= len_nxt;     raddr_r <= raddr_nxt; rtype_r <= rtype_nxt;
      sum_r <= sum_nxt;     pend_r <= pend_nxt;   upper_r <= upper_nxt;
      bad_r <= bad_nxt;     eof_r <= eof_nxt;     halted_r <= halted_nxt;
      seen_r <= seen_nxt;   high_r <= high_nxt;   hbad_r <= hbad_nxt;
    end
  end

  `IHEX_ASSERT_NEXT(a_halt_sticks, halted_r, halted_r)
  `IHEX_ASSERT_NOW(a_quiet_when_halted, halted_r, !res_valid)
  `IHEX_ASSERT_NEXT(a_final_halts, res_valid && res.kind != KIND_WRITE, halted_r)
  `IHEX_ASSERT_NEXT(a_write_marks_data, res_valid && res.kind == KIND_WRITE, seen_r)

endmodule

// ===== src/ihex_out_reg.sv =====
// Result register of the Intel HEX record parser: holds one result item until it is taken.
// Depends on ihex_pkg.
module ihex_out_reg
  import ihex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  ihex_out_t res,
  output logic      res_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output ihex_out_t out_item
);

  logic      valid_r, valid_nxt;
  ihex_out_t item_r;

  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_ready && res_valid) item_r <= res;
  end

endmodule

// ===== src/intel_hex_record_parser.sv =====
// Intel HEX record parser top level: input register, decoding core and result register.
// Depends on ihex_pkg, ihex_in_reg, ihex_core and ihex_out_reg.
// The parser takes one character item per clock while its input does not stall and gives
// at most one result item per character. A character is caught in the input register,
// decoded by the core and its result is loaded into the result register, from which it
// is offered. The core updates the record state once per character and sustains one
// item per cycle whenever the result side is not stalling; a stalled result holds the
// core, and the input stalls once the input register is occupied as well.
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ihex_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output ihex_out_t out_item
);

  logic      res_ready;
  logic      s1_valid;
  ihex_in_t  s1_item;
  logic      res_valid;
  ihex_out_t res;

  ihex_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_ready (res_ready),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  ihex_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid && res_ready),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ihex_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/tb_intel_hex_record_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Intel HEX record parser: drives hex text item by item,
// predicts every write, completion and error in its own parser copy and checks each result.
// Depends on ihex_pkg and intel_hex_record_parser.
module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  typedef enum int {
    END_EOF_RECORD, END_OPEN_LINE, END_AT_NEWLINE, BAD_START, SHORT_LINE,
    BAD_DIGIT, TRUNCATED, BAD_SUM, BAD_OPEN_LINE
  } finish_mode_e;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ihex_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ihex_out_t out_item;

  ihex_out_t  decoded_q[$];
  logic [7:0] line_chars[$];
  logic [7:0] payload[$];
  int         fail_count = 0;
  int         chars_sent = 0;
  bit         tx_idle = 1'b0;
  bit         rx_idle = 1'b0;
  bit         hold_req = 1'b0;
  bit         no_data_run = 1'b0;

  logic [9:0]  pos = '0;
  bit          colon_seen = 1'b0;
  logic [3:0]  hi_nib = '0;
  bit          hi_bad = 1'b0;
  logic [7:0]  rec_len = '0;
  logic [15:0] rec_addr = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  sum_acc = '0;
  logic [15:0] upper_pending = '0;
  logic [15:0] upper_base = '0;
  bit          pair_bad = 1'b0;
  bit          eof_seen = 1'b0;
  bit          parser_halted = 1'b0;
  bit          wrote_any = 1'b0;
  logic [31:0] top_addr = '0;

  intel_hex_record_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    return -1;
  endfunction

  function automatic void clear_record_state();
    pos = '0;
    colon_seen = 1'b0;
    hi_nib = '0;
    hi_bad = 1'b0;
    rec_len = '0;
    rec_addr = '0;
    rec_type = '0;
    sum_acc = '0;
    upper_pending = '0;
    pair_bad = 1'b0;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [31:0] addr,
                                      input logic [7:0] data, input logic [2:0] code);
    ihex_out_t r;
    r.kind = kind;
    r.address = addr;
    r.data = data;
    r.fault_code = code;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic int close_line();
    int err;
    err = -1;
    if (!colon_seen || pos < MIN_LINE) err = int'(ERR_START);
    else if (pair_bad) err = int'(ERR_DIGIT);
    else if (int'(pos) < int'(MIN_LINE) + 2 * int'(rec_len)) err = int'(ERR_TRUNC);
    else if (sum_acc != 8'h00) err = int'(ERR_SUM);
    else if (rec_type == REC_EOF) eof_seen = 1'b1;
    else if (rec_type == REC_UPPER && rec_len == 8'd2) upper_base = upper_pending;
    clear_record_state();
    return err;
  endfunction

  function automatic void decode_char(input ihex_in_t it);
    int err;
    int p;
    int q;
    int k;
    int v;
    int i;
    logic [7:0] b;
    logic [31:0] a;
    if (parser_halted) return;
    if (it.end_of_input) begin
      if (!eof_seen && pos != 0) begin
        err = close_line();
        if (err >= 0) begin
          parser_halted = 1'b1;
          push_result(KIND_ERROR, '0, '0, 3'(err));
          return;
        end
      end
      parser_halted = 1'b1;
      if (!wrote_any) push_result(KIND_ERROR, '0, '0, ERR_EMPTY);
      else push_result(KIND_DONE, top_addr, '0, '0);
      return;
    end
    if (eof_seen) return;
    if (it.ch == CH_NL) begin
      if (pos == 0) return;
      err = close_line();
      if (err >= 0) begin
        parser_halted = 1'b1;
        push_result(KIND_ERROR, '0, '0, 3'(err));
      end
      return;
    end
    p = int'(pos);
    if (pos < POS_MAX) pos = pos + 10'd1;
    if (p == 0) begin
      colon_seen = (it.ch == CH_COLON);
      return;
    end
    if (p >= int'(POS_MAX)) return;
    q = p - 1;
    k = q / 2;
    v = hex_digit(it.ch);
    if (q % 2 == 0) begin
      hi_bad = (v < 0);
      hi_nib = (v < 0) ? 4'h0 : 4'(v);
      return;
    end
    if (k >= 4 && k > 4 + int'(rec_len)) return;
    if (hi_bad || v < 0) pair_bad = 1'b1;
    b = {hi_nib, (v < 0) ? 4'h0 : 4'(v)};
    sum_acc = sum_acc + b;
    if (k == 0) rec_len = b;
    else if (k == 1) rec_addr[15:8] = b;
    else if (k == 2) rec_addr[7:0] = b;
    else if (k == 3) rec_type = b;
    else if (k < 4 + int'(rec_len)) begin
      i = k - 4;
      if (rec_type == REC_DATA && colon_seen && !pair_bad) begin
        a = {upper_base, 16'h0000} + 32'(rec_addr) + 32'(i);
        if (!wrote_any || a > top_addr) top_addr = a;
        wrote_any = 1'b1;
        push_result(KIND_WRITE, a, b, '0);
      end else if (rec_type == REC_UPPER) begin
        if (i == 0) upper_pending[15:8] = b;
        else if (i == 1) upper_pending[7:0] = b;
      end
    end
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    line_chars.insert(line_chars.size(), c);
  endfunction

  function automatic void add_payload(input logic [7:0] b);
    payload.insert(payload.size(), b);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_char(nibble_char(b[7:4]));
    add_char(nibble_char(b[3:0]));
  endfunction

  function automatic void fill_payload(input int n);
    repeat (n) add_payload(8'($urandom));
  endfunction

  function automatic void add_noise(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom);
      if (c == CH_NL) c = ~c;
      add_char(c);
    end
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom); while (hex_digit(c) >= 0 || c == CH_NL || c == CH_COLON);
    return c;
  endfunction

  // The record takes the payload queue as its data bytes and ends in a correct checksum.
  function automatic void build_record(input logic [7:0] typ, input logic [15:0] addr);
    logic [7:0] t;
    logic [7:0] sum;
    t = (no_data_run && typ == REC_DATA) ? 8'h03 : typ;
    sum = 8'(payload.size()) + addr[15:8] + addr[7:0] + t;
    add_char(CH_COLON);
    add_byte(8'(payload.size()));
    add_byte(addr[15:8]);
    add_byte(addr[7:0]);
    add_byte(t);
    foreach (payload[j]) begin
      add_byte(payload[j]);
      sum = sum + payload[j];
    end
    add_byte(8'h00 - sum);
    payload.delete();
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eoi);
    ihex_in_t it;
    it.ch = c;
    it.end_of_input = eoi;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_char(it);
    chars_sent++;
  endtask

  task automatic send_line(input bit with_nl);
    foreach (line_chars[j]) send_char(line_chars[j], 1'b0);
    if (with_nl) send_char(CH_NL, 1'b0);
    line_chars.delete();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    ihex_out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result item, got %p", $time, out_item);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_item.kind));
        check_field("address", want.address, out_item.address);
        check_field("data", 32'(want.data), 32'(out_item.data));
        check_field("fault_code", 32'(want.fault_code), 32'(out_item.fault_code));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_record_types();
    send_char(CH_NL, 1'b0);
    send_char(CH_NL, 1'b0);
    add_payload(8'h00);
    build_record(REC_DATA, 16'h0000);
    send_line(1'b1);
    add_payload(8'hff);
    add_payload(8'h00);
    build_record(REC_DATA, 16'hffff);
    send_line(1'b1);
    fill_payload(2);
    build_record(8'h02, 16'h0000);
    send_line(1'b1);
    add_payload(8'hff);
    add_payload(8'hff);
    build_record(REC_UPPER, 16'h0000);
    send_line(1'b1);
    fill_payload(4);
    build_record(REC_DATA, 16'hfffe);
    send_line(1'b1);
    fill_payload(3);
    build_record(REC_UPPER, 16'h0000);
    send_line(1'b1);
    fill_payload(1);
    build_record(REC_UPPER, 16'h0000);
    send_line(1'b1);
    add_payload(8'h00);
    add_payload(8'h00);
    build_record(REC_UPPER, 16'hffff);
    send_line(1'b1);
    build_record(REC_DATA, 16'h1234);
    send_line(1'b1);
    fill_payload(3);
    build_record(REC_DATA, 16'h7f00);
    add_char(8'hff);
    add_char(CH_COLON);
    add_char(8'h80);
    add_char(8'h00);
    send_line(1'b1);
  endtask

  task automatic test_long_line();
    fill_payload(255);
    build_record(REC_DATA, 16'h8000);
    add_noise(1030 - line_chars.size());
    send_line(1'b1);
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    fill_payload(32);
    build_record(REC_DATA, 16'($urandom));
    send_line(1'b1);
  endtask

  task automatic test_random_records();
    int start;
    int pick;
    start = chars_sent;
    while (chars_sent - start < 200) begin
      if (chars_sent - start > 140) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                 : $urandom_range(0, 16));
        build_record(REC_DATA, 16'($urandom));
      end else if (pick < 77) begin
        fill_payload(2);
        build_record(REC_UPPER, 16'($urandom));
      end else if (pick < 82) begin
        fill_payload($urandom_range(0, 5));
        build_record(REC_UPPER, 16'($urandom));
      end else if (pick < 90) begin
        fill_payload($urandom_range(0, 8));
        build_record(8'($urandom_range(2, 255)), 16'($urandom));
      end else if (pick >= 95) begin
        fill_payload($urandom_range(1, 8));
        build_record(REC_DATA, 16'($urandom));
        add_noise($urandom_range(1, 12));
      end
      send_line(1'b1);
    end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
  endtask

  task automatic test_stream_end();
    finish_mode_e mode;
    logic [7:0] last;
    mode = finish_mode_e'($urandom_range(0, 8));
    if (mode == END_EOF_RECORD) begin
      build_record(REC_EOF, 16'h0000);
      send_line(1'b1);
      add_noise(6);
      send_line(1'b1);
      fill_payload(2);
      build_record(REC_DATA, 16'($urandom));
      send_line(1'b1);
    end else if (mode == END_OPEN_LINE) begin
      fill_payload($urandom_range(1, 8));
      build_record(REC_DATA, 16'($urandom));
      send_line(1'b0);
    end else if (mode != END_AT_NEWLINE) begin
      fill_payload($urandom_range(2, 8));
      build_record(REC_DATA, 16'($urandom));
      case (mode)
        BAD_START: begin
          line_chars[0] = bad_char();
        end
        SHORT_LINE: begin
          last = 8'($urandom_range(1, 10));
          while (line_chars.size() > last) void'(line_chars.pop_back());
        end
        BAD_DIGIT, BAD_OPEN_LINE: begin
          line_chars[$urandom_range(1, line_chars.size() - 1)] = bad_char();
        end
        TRUNCATED: begin
          repeat ($urandom_range(1, 4)) void'(line_chars.pop_back());
          if ($urandom_range(0, 1)) line_chars[line_chars.size() - 1] = bad_char();
        end
        BAD_SUM: begin
          last = line_chars[line_chars.size() - 1];
          line_chars[line_chars.size() - 1] = (last == 8'h30) ? 8'h31 : 8'h30;
        end
        default: begin
        end
      endcase
      send_line(mode != BAD_OPEN_LINE);
    end
    // Without any writes the final result is the only one that can back up the block.
    if (no_data_run) hold_req = 1'b1;
    send_char(8'($urandom), 1'b1);
    fill_payload(2);
    build_record(REC_DATA, 16'($urandom));
    add_noise(4);
    send_line(1'b1);
    send_char(8'($urandom), 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    no_data_run = ($urandom_range(0, 9) == 0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_record_types();
    test_long_line();
    test_output_backpressure();
    test_random_records();
    test_stream_end();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
